// File: sv/floor_display_pulse_encoder_macros.svh
`ifndef FLOOR_DISPLAY_PULSE_ENCODER_MACROS_SVH
`define FLOOR_DISPLAY_PULSE_ENCODER_MACROS_SVH

// same-cycle implication, checked only out of reset
`define FDPE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fdpe check failed");

// next-cycle implication, checked only out of reset
`define FDPE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fdpe check failed");

`endif

// File: sv/fdpe_pkg.sv
package fdpe_pkg;

    localparam int unsigned POS_W      = 7;
    localparam int unsigned DIR_W      = 3;
    localparam int unsigned SYM_W      = 5;
    localparam int unsigned FRAME_W    = 13;
    localparam int unsigned BIT_IDX_W  = 4;
    localparam int unsigned CHIP_IDX_W = 3;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [SYM_W-1:0] SYM_S     = 5'd22;
    localparam logic [SYM_W-1:0] SYM_L     = 5'd19;
    localparam logic [SYM_W-1:0] SYM_T     = 5'd12;
    localparam logic [SYM_W-1:0] SYM_BLANK = 5'd10;

    localparam logic [BIT_IDX_W-1:0]  PHASE_HIGH     = 4'd13;
    localparam logic [BIT_IDX_W-1:0]  PHASE_LOW      = 4'd14;
    localparam logic [CHIP_IDX_W-1:0] LAST_BIT_CHIP  = 3'd3;
    localparam logic [CHIP_IDX_W-1:0] LAST_TRL_CHIP  = 3'd4;

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef struct packed {
        logic             func;
        logic [POS_W-1:0] position;
        logic [DIR_W-1:0] direction;
    } t_item;

    // tens by reciprocal multiply, exact for all 7-bit values
    function automatic logic [FRAME_W-1:0] build_frame(
        input logic [POS_W-1:0] pos,
        input logic [DIR_W-1:0] dir
    );
        logic [14:0]      prod;
        logic [3:0]       tens_d;
        logic [POS_W-1:0] units_d;
        logic [SYM_W-1:0] tens;
        logic [SYM_W-1:0] units;
        prod    = 15'(pos) * 15'd205;
        tens_d  = prod[14:11];
        units_d = pos - (7'(tens_d) * 7'd10);
        if (pos == 7'd0) begin
            tens  = SYM_BLANK;
            units = SYM_T;
        end else if (pos == 7'd1) begin
            tens  = SYM_S;
            units = SYM_L;
        end else if (pos < 7'd10) begin
            tens  = SYM_BLANK;
            units = pos[SYM_W-1:0];
        end else begin
            tens  = SYM_W'(tens_d);
            units = units_d[SYM_W-1:0];
        end
        return {dir, tens, units};
    endfunction

endpackage

// File: sv/fdpe_in_stage.sv
module fdpe_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  fdpe_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output fdpe_pkg::t_item o_item
);

    logic            r_valid;
    logic            n_valid;
    fdpe_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/fdpe_chip_gen.sv
`include "floor_display_pulse_encoder_macros.svh"

module fdpe_chip_gen (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  fdpe_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_level,
    output logic            o_end
);

    logic [fdpe_pkg::POS_W-1:0]      r_pos;
    logic [fdpe_pkg::DIR_W-1:0]      r_dir;
    logic [fdpe_pkg::FRAME_W-1:0]    r_frame;
    logic [fdpe_pkg::BIT_IDX_W-1:0]  r_bit_idx;
    logic [fdpe_pkg::CHIP_IDX_W-1:0] r_chip_idx;
    logic                            r_out_valid;
    logic                            r_out_level;
    logic                            r_out_end;

    logic [fdpe_pkg::FRAME_W-1:0]    n_frame;
    logic [fdpe_pkg::BIT_IDX_W-1:0]  n_bit_idx;
    logic [fdpe_pkg::CHIP_IDX_W-1:0] n_chip_idx;
    logic                            n_out_valid;
    logic                            n_level;
    logic                            n_end;

    logic [fdpe_pkg::BIT_IDX_W-1:0]  bi;
    logic [fdpe_pkg::CHIP_IDX_W-1:0] ci;
    logic                            take;
    logic                            tick;
    logic                            upd;
    logic                            cur_bit;

    assign o_ready = !r_out_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign tick    = take && (i_item.func == fdpe_pkg::FUNC_TICK);
    assign upd     = take && (i_item.func == fdpe_pkg::FUNC_UPDATE);

    always_comb begin
        bi = r_bit_idx;
        ci = r_chip_idx;
        // out-of-range index restarts the frame
        if (r_bit_idx > fdpe_pkg::PHASE_LOW) begin
            bi = '0;
            ci = '0;
        end
        n_frame = r_frame;
        if (bi == '0 && ci == '0) begin
            n_frame = fdpe_pkg::build_frame(r_pos, r_dir);
        end
        cur_bit    = (bi < 4'(fdpe_pkg::FRAME_W)) ? n_frame[bi] : 1'b0;
        n_end      = 1'b0;
        n_bit_idx  = bi;
        n_chip_idx = ci;
        if (bi < 4'(fdpe_pkg::FRAME_W)) begin
            n_level = (ci == '0) || (!cur_bit && ci < fdpe_pkg::LAST_BIT_CHIP);
            if (ci >= fdpe_pkg::LAST_BIT_CHIP) begin
                n_chip_idx = '0;
                n_bit_idx  = bi + 4'd1;
            end else begin
                n_chip_idx = ci + 3'd1;
            end
        end else begin
            n_level = (bi == fdpe_pkg::PHASE_HIGH);
            if (ci >= fdpe_pkg::LAST_TRL_CHIP) begin
                n_chip_idx = '0;
                if (bi == fdpe_pkg::PHASE_LOW) begin
                    n_bit_idx = '0;
                    n_end     = 1'b1;
                end else begin
                    n_bit_idx = fdpe_pkg::PHASE_LOW;
                end
            end else begin
                n_chip_idx = ci + 3'd1;
            end
        end
    end

    assign n_out_valid = tick || (r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_dir       <= '0;
            r_frame     <= '0;
            r_bit_idx   <= '0;
            r_chip_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (upd) begin
                r_pos <= i_item.position;
                r_dir <= i_item.direction;
            end
            if (tick) begin
                r_frame    <= n_frame;
                r_bit_idx  <= n_bit_idx;
                r_chip_idx <= n_chip_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out_level <= n_level;
            r_out_end   <= n_end;
        end
    end

    assign o_valid = r_out_valid;
    assign o_level = r_out_level;
    assign o_end   = r_out_end;

    `FDPE_ASSERT_NOW(a_bit_range, 1'b1, r_bit_idx <= fdpe_pkg::PHASE_LOW)
    `FDPE_ASSERT_NOW(a_chip_range, 1'b1, r_chip_idx <= fdpe_pkg::LAST_TRL_CHIP)
    `FDPE_ASSERT_NOW(a_end_low, r_out_valid && r_out_end, !r_out_level)
    `FDPE_ASSERT_NEXT(a_end_restart, tick && n_end, r_bit_idx == '0 && r_chip_idx == '0)
    `FDPE_ASSERT_NEXT(a_upd_silent, upd, !r_out_valid)

endmodule

// File: sv/floor_display_pulse_encoder.sv
// one-wire floor indicator encoder: an update item (tuser 0) stores a position and direction,
// a tick item (tuser 1) yields one line chip on the master side, with tlast on the 62nd chip
// of each frame; position and direction are latched at each frame start, so updates land on
// the next frame; one item is taken every cycle while the master side does not stall, and
// each tick's chip passes through the input register and then the chip register
module floor_display_pulse_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,  // position[6:0], direction[9:7], zero pad
    input  logic        i_s_tuser,  // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,  // line_level[0], zero pad
    output logic        o_m_tlast
);

    fdpe_pkg::t_item in_item;
    fdpe_pkg::t_item st_item;
    logic            st_valid;
    logic            st_ready;
    logic            level;

    assign in_item.func      = i_s_tuser;
    assign in_item.position  = i_s_tdata[fdpe_pkg::POS_W-1:0];
    assign in_item.direction = i_s_tdata[fdpe_pkg::POS_W +: fdpe_pkg::DIR_W];

    fdpe_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .i_ready (st_ready),
        .o_item  (st_item)
    );

    fdpe_chip_gen u_chip_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid),
        .o_ready (st_ready),
        .i_item  (st_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_level (level),
        .o_end   (o_m_tlast)
    );

    assign o_m_tdata = {7'b0, level};

endmodule

// File: verif/testbench.sv
module testbench;

    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_ITEMS    = 780;
    localparam int QUIET_ITEMS     = 150;

    typedef struct packed {
        logic level;
        logic frame_end;
    } t_chip;

    class chip_scoreboard;
        logic [fdpe_pkg::POS_W-1:0]      cur_pos;
        logic [fdpe_pkg::DIR_W-1:0]      cur_dir;
        logic [fdpe_pkg::FRAME_W-1:0]    frame_word;
        logic [fdpe_pkg::BIT_IDX_W-1:0]  bit_idx;
        logic [fdpe_pkg::CHIP_IDX_W-1:0] chip_idx;
        t_chip                           expected_chips[$];
        int                              mismatches;

        function new();
            cur_pos    = '0;
            cur_dir    = '0;
            frame_word = '0;
            bit_idx    = '0;
            chip_idx   = '0;
            mismatches = 0;
        endfunction

        function logic [fdpe_pkg::FRAME_W-1:0] encode_frame(
            logic [fdpe_pkg::POS_W-1:0] p,
            logic [fdpe_pkg::DIR_W-1:0] d
        );
            logic [fdpe_pkg::SYM_W-1:0] tens;
            logic [fdpe_pkg::SYM_W-1:0] units;
            if (p == 0) begin
                tens  = fdpe_pkg::SYM_BLANK;
                units = fdpe_pkg::SYM_T;
            end else if (p == 1) begin
                tens  = fdpe_pkg::SYM_S;
                units = fdpe_pkg::SYM_L;
            end else if (p < 10) begin
                tens  = fdpe_pkg::SYM_BLANK;
                units = fdpe_pkg::SYM_W'(p);
            end else begin
                tens  = fdpe_pkg::SYM_W'(p / 10);
                units = fdpe_pkg::SYM_W'(p % 10);
            end
            return {d, tens, units};
        endfunction

        function void note_item(fdpe_pkg::t_item it);
            t_chip c;
            logic  b;
            if (it.func == fdpe_pkg::FUNC_UPDATE) begin
                cur_pos = it.position;
                cur_dir = it.direction;
                return;
            end
            if (bit_idx > fdpe_pkg::PHASE_LOW) begin
                bit_idx  = '0;
                chip_idx = '0;
            end
            if (bit_idx == 0 && chip_idx == 0)
                frame_word = encode_frame(cur_pos, cur_dir);
            c.frame_end = 1'b0;
            if (bit_idx < fdpe_pkg::FRAME_W) begin
                b       = frame_word[bit_idx];
                c.level = (chip_idx == 0) || (!b && chip_idx < 3);
                if (chip_idx >= fdpe_pkg::LAST_BIT_CHIP) begin
                    chip_idx = '0;
                    bit_idx  = bit_idx + 1'b1;
                end else begin
                    chip_idx = chip_idx + 1'b1;
                end
            end else begin
                c.level = (bit_idx == fdpe_pkg::PHASE_HIGH);
                if (chip_idx >= fdpe_pkg::LAST_TRL_CHIP) begin
                    chip_idx = '0;
                    if (bit_idx == fdpe_pkg::PHASE_LOW) begin
                        bit_idx     = '0;
                        c.frame_end = 1'b1;
                    end else begin
                        bit_idx = fdpe_pkg::PHASE_LOW;
                    end
                end else begin
                    chip_idx = chip_idx + 1'b1;
                end
            end
            expected_chips.push_back(c);
        endfunction

        function void check_chip(logic [fdpe_pkg::OUT_DATA_W-1:0] data, logic last);
            t_chip c;
            if (expected_chips.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected chip: tdata %0h tlast %0d", data, last);
                return;
            end
            c = expected_chips.pop_front();
            if (data !== {{(fdpe_pkg::OUT_DATA_W-1){1'b0}}, c.level} ||
                last !== c.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("chip mismatch: expected level %0d tlast %0d, got tdata %0h tlast %0d",
                             c.level, c.frame_end, data, last);
            end
        endfunction

        function int pending();
            return expected_chips.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [fdpe_pkg::IN_DATA_W-1:0]  i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [fdpe_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            o_m_tlast;

    chip_scoreboard sb = new();
    bit             stall_request = 1'b0;
    bit             quiet_phase   = 1'b0;
    int             idle_cycles   = 0;

    floor_display_pulse_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic send_item(input logic f, input logic [fdpe_pkg::POS_W-1:0] p,
                             input logic [fdpe_pkg::DIR_W-1:0] d);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(fdpe_pkg::IN_DATA_W-fdpe_pkg::POS_W-fdpe_pkg::DIR_W){1'b0}}, d, p};
        i_s_tuser  <= f;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic send_tick();
        send_item(fdpe_pkg::FUNC_TICK, fdpe_pkg::POS_W'($urandom),
                  fdpe_pkg::DIR_W'($urandom));
    endtask

    function automatic logic [fdpe_pkg::POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return fdpe_pkg::POS_W'($urandom_range(0, 9));
        else if (r < 8)
            return fdpe_pkg::POS_W'($urandom_range(10, 99));
        else if (r == 8)
            return fdpe_pkg::POS_W'($urandom_range(100, 127));
        else
            return fdpe_pkg::POS_W'($urandom_range(0, 1));
    endfunction

    // item and chip monitor
    always @(posedge i_clk) begin
        fdpe_pkg::t_item it;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                sb.check_chip(o_m_tdata, o_m_tlast);
            if (i_s_tvalid && o_s_tready) begin
                it.func      = i_s_tuser;
                it.position  = i_s_tdata[fdpe_pkg::POS_W-1:0];
                it.direction = i_s_tdata[fdpe_pkg::POS_W +: fdpe_pkg::DIR_W];
                sb.note_item(it);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver side
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (!quiet_phase) begin
            if (stall_request && !hold_done) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
        i_m_tready <= 1'b1;
    end

    // sender side
    initial begin
        int i;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= fdpe_pkg::FUNC_UPDATE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // symbol extremes, updates landing mid-frame
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd1, 3'd7);
        repeat (3) send_tick();
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd0, 3'd0);
        send_tick();
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd127, 3'd7);
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd100, 3'd1);
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd99, 3'd4);
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd10, 3'd2);
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd9, 3'd5);
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd2, 3'd3);
        send_item(fdpe_pkg::FUNC_TICK, 7'd127, 3'd7);
        send_item(fdpe_pkg::FUNC_TICK, 7'd0, 3'd0);
        repeat (4) send_tick();
        send_item(fdpe_pkg::FUNC_UPDATE, 7'd0, 3'd6);
        repeat (3) send_tick();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 100)
                stall_request = 1'b1;
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet_phase = 1'b1;
            if ($urandom_range(0, 99) < 15)
                send_item(fdpe_pkg::FUNC_UPDATE, pick_position(), fdpe_pkg::DIR_W'($urandom));
            else
                send_tick();
            if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
